// ----- sv/rsie_pkg.sv -----
// shared types, constants and instruction codes for the rv32i subset executor
// no dependencies; every other file except rsie_ram imports this package
`default_nettype none

package rsie_pkg;

	localparam int DATA_WORDS    = 1024;
	localparam int PROGRAM_SLOTS = 1024;
	localparam int DW_AW         = $clog2(DATA_WORDS);
	localparam int RF_DEPTH      = 32;

	localparam logic signed [31:0] DATA_BASE = 32'sd268500992;
	// first byte address past the data memory
	localparam logic signed [32:0] DATA_END  = 33'(268500992 + 4 * DATA_WORDS);
	localparam logic signed [31:0] PC_LIMIT  = 32'(PROGRAM_SLOTS);

	localparam logic [4:0] ACT_ADD  = 5'd0;
	localparam logic [4:0] ACT_SLT  = 5'd1;
	localparam logic [4:0] ACT_AND  = 5'd2;
	localparam logic [4:0] ACT_OR   = 5'd3;
	localparam logic [4:0] ACT_XOR  = 5'd4;
	localparam logic [4:0] ACT_SLL  = 5'd5;
	localparam logic [4:0] ACT_SRL  = 5'd6;
	localparam logic [4:0] ACT_SUB  = 5'd7;
	localparam logic [4:0] ACT_ADDI = 5'd8;
	localparam logic [4:0] ACT_SLTI = 5'd9;
	localparam logic [4:0] ACT_ANDI = 5'd10;
	localparam logic [4:0] ACT_ORI  = 5'd11;
	localparam logic [4:0] ACT_XORI = 5'd12;
	localparam logic [4:0] ACT_JALR = 5'd13;
	localparam logic [4:0] ACT_BEQ  = 5'd14;
	localparam logic [4:0] ACT_BNE  = 5'd15;
	localparam logic [4:0] ACT_BLT  = 5'd16;
	localparam logic [4:0] ACT_BGE  = 5'd17;
	localparam logic [4:0] ACT_BLE  = 5'd18;
	localparam logic [4:0] ACT_J    = 5'd19;
	localparam logic [4:0] ACT_JAL  = 5'd20;
	localparam logic [4:0] ACT_LI   = 5'd21;
	localparam logic [4:0] ACT_LW   = 5'd22;
	localparam logic [4:0] ACT_SW   = 5'd23;
	localparam logic [4:0] ACT_EXIT = 5'd24;

	localparam logic [1:0] FLT_NONE  = 2'd0;
	localparam logic [1:0] FLT_LABEL = 2'd1;
	localparam logic [1:0] FLT_LOW   = 2'd2;
	localparam logic [1:0] FLT_HIGH  = 2'd3;

	typedef struct packed {
		logic [4:0]         action;
		logic [4:0]         dest_reg;
		logic [4:0]         src_reg_a;
		logic [4:0]         src_reg_b;
		logic signed [31:0] immediate;
		logic [9:0]         target_index;
		logic               target_known;
		logic               label_given;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] next_pc;
		logic               reg_written;
		logic [4:0]         written_reg;
		logic signed [31:0] written_value;
		logic [1:0]         fault;
		logic               halted;
	} out_item_t;

	typedef struct packed {
		logic use_imm;
		logic writes;
		logic is_branch;
		logic is_jal;
		logic is_jalr;
		logic is_lw;
		logic is_sw;
		logic is_exit;
	} cls_t;

	typedef struct packed {
		in_item_t item;
		cls_t     cls;
	} dec_t;

endpackage

`default_nettype wire

// ----- sv/rsie_if.sv -----
// valid/ready channel interfaces for instructions and results
// depends on rsie_pkg
`default_nettype none

interface rsie_in_if import rsie_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rsie_out_if import rsie_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/rsie_ram.sv -----
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module rsie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/rsie_front.sv -----
// front end: takes instructions and classifies them by opcode
// depends on rsie_pkg and rsie_if
`default_nettype none

module rsie_front import rsie_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rsie_in_if.sink    inst,
	output      logic  push,
	output      dec_t  push_data,
	input  wire logic  push_ready
);

	logic f_valid_q;
	dec_t f_q;
	cls_t cls;

	assign inst.ready = !f_valid_q || push_ready;
	assign push       = f_valid_q;
	assign push_data  = f_q;

	always_comb begin
		cls = '0;
		case (inst.data.action)
			ACT_ADD, ACT_SLT, ACT_AND, ACT_OR, ACT_XOR, ACT_SLL, ACT_SRL, ACT_SUB: begin
				cls.writes = 1'b1;
			end
			ACT_ADDI, ACT_SLTI, ACT_ANDI, ACT_ORI, ACT_XORI, ACT_LI: begin
				cls.writes  = 1'b1;
				cls.use_imm = 1'b1;
			end
			ACT_JALR: begin
				cls.writes  = 1'b1;
				cls.use_imm = 1'b1;
				cls.is_jalr = 1'b1;
			end
			ACT_BEQ, ACT_BNE, ACT_BLT, ACT_BGE, ACT_BLE, ACT_J: begin
				cls.is_branch = 1'b1;
			end
			ACT_JAL: begin
				cls.writes = 1'b1;
				cls.is_jal = 1'b1;
			end
			ACT_LW: begin
				cls.writes  = 1'b1;
				cls.use_imm = 1'b1;
				cls.is_lw   = 1'b1;
			end
			ACT_SW: begin
				cls.is_sw = 1'b1;
			end
			ACT_EXIT: begin
				cls.is_exit = 1'b1;
			end
			default: begin
				cls = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_q <= 1'b0;
		end else if (inst.ready) begin
			f_valid_q <= inst.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (inst.ready && inst.valid) begin
			f_q.item <= inst.data;
			f_q.cls  <= cls;
		end
	end

endmodule

`default_nettype wire

// ----- sv/rsie_queue.sv -----
// two-entry queue between front end and execution back end
// depends on rsie_pkg
`default_nettype none

module rsie_queue import rsie_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire dec_t push_data,
	output      logic push_ready,
	output      logic head_valid,
	output      dec_t head,
	input  wire logic pop
);

	dec_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = ent_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- sv/rsie_back.sv -----
// execution back end: register file, data memory, program counter, result register
// depends on rsie_pkg, rsie_if and rsie_ram
`default_nettype none

module rsie_back import rsie_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire dec_t head,
	output      logic pop,
	rsie_out_if.source res
);

	logic                 adv;
	logic                 clr_busy_q;
	logic [DW_AW-1:0]     clr_idx_q;
	logic [RF_DEPTH-1:0]  rv_q;

	logic                 s1_valid;
	dec_t                 s1_d;
	logic                 s1_va;
	logic                 s1_vb;

	logic                 s2_valid;
	out_item_t            s2_d;
	logic                 s2_load;

	logic                 wb_valid_q;
	logic [4:0]           wb_rd_q;
	logic [31:0]          wb_val_q;

	logic [31:0]          pc_q;
	logic                 halt_q;

	logic [31:0]          rf_a;
	logic [31:0]          rf_b;
	logic [31:0]          dm_rdata;
	logic [31:0]          s2_val;
	logic                 wb_en;

	logic [31:0]          a;
	logic [31:0]          b;
	logic [31:0]          opb;
	logic [31:0]          sum;
	logic [31:0]          maddr;
	logic [31:0]          moff;
	logic [31:0]          pc1;
	logic [31:0]          tgt;
	logic                 stop;
	logic                 lt;
	logic                 eq;
	logic [1:0]           mfault;

	out_item_t            nx;
	logic                 nx_load;
	logic                 st_en;
	logic                 halt_set;
	logic [31:0]          value;
	logic                 wr;
	logic                 taken;

	logic                 dm_we;
	logic [DW_AW-1:0]     dm_waddr;
	logic [31:0]          dm_wdata;

	assign adv    = !s2_valid || res.ready;
	assign pop    = adv && head_valid && !clr_busy_q;
	assign s2_val = s2_load ? dm_rdata : s2_d.written_value;
	assign wb_en  = adv && s2_valid && s2_d.reg_written;

	assign res.valid              = s2_valid;
	assign res.data.next_pc       = s2_d.next_pc;
	assign res.data.reg_written   = s2_d.reg_written;
	assign res.data.written_reg   = s2_d.written_reg;
	assign res.data.written_value = s2_val;
	assign res.data.fault         = s2_d.fault;
	assign res.data.halted        = s2_d.halted;

	rsie_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk   (clk),
		.we    (wb_en),
		.waddr (s2_d.written_reg),
		.wdata (s2_val),
		.re    (pop),
		.raddr (head.item.src_reg_a),
		.rdata (rf_a)
	);

	rsie_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk   (clk),
		.we    (wb_en),
		.waddr (s2_d.written_reg),
		.wdata (s2_val),
		.re    (pop),
		.raddr (head.item.src_reg_b),
		.rdata (rf_b)
	);

	assign dm_we    = clr_busy_q || (adv && s1_valid && st_en);
	assign dm_waddr = clr_busy_q ? clr_idx_q : moff[DW_AW+1:2];
	assign dm_wdata = clr_busy_q ? '0 : a;

	rsie_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (adv),
		.raddr (moff[DW_AW+1:2]),
		.rdata (dm_rdata)
	);

	// operand bypass: result stage first, then the registered last write-back, then the file
	always_comb begin
		if (s2_valid && s2_d.reg_written && s2_d.written_reg == s1_d.item.src_reg_a) begin
			a = s2_val;
		end else if (wb_valid_q && wb_rd_q == s1_d.item.src_reg_a) begin
			a = wb_val_q;
		end else begin
			a = s1_va ? rf_a : '0;
		end
		if (s2_valid && s2_d.reg_written && s2_d.written_reg == s1_d.item.src_reg_b) begin
			b = s2_val;
		end else if (wb_valid_q && wb_rd_q == s1_d.item.src_reg_b) begin
			b = wb_val_q;
		end else begin
			b = s1_vb ? rf_b : '0;
		end
	end

	assign opb   = s1_d.cls.use_imm ? s1_d.item.immediate : b;
	assign sum   = a + opb;
	assign lt    = $signed(a) < $signed(opb);
	assign eq    = a == b;
	assign maddr = s1_d.cls.is_sw ? (b + s1_d.item.immediate) : sum;
	assign moff  = maddr - DATA_BASE;
	assign pc1   = pc_q + 32'd1;
	assign tgt   = {22'd0, s1_d.item.target_index};
	assign stop  = halt_q || $signed(pc_q) < 0 || $signed(pc_q) >= PC_LIMIT;

	always_comb begin
		if ($signed(maddr) < DATA_BASE) begin
			mfault = FLT_LOW;
		end else if ($signed({maddr[31], maddr}) >= DATA_END) begin
			mfault = FLT_HIGH;
		end else begin
			mfault = FLT_NONE;
		end
	end

	always_comb begin
		nx       = '0;
		nx_load  = 1'b0;
		st_en    = 1'b0;
		halt_set = 1'b0;
		value    = '0;
		wr       = 1'b0;
		taken    = 1'b0;
		nx.next_pc = pc1;
		if (stop || s1_d.cls.is_exit) begin
			halt_set   = 1'b1;
			nx.halted  = 1'b1;
			nx.next_pc = pc_q;
		end else begin
			wr = s1_d.cls.writes;
			case (s1_d.item.action)
				ACT_ADD, ACT_ADDI: value = sum;
				ACT_SLT, ACT_SLTI: value = {31'd0, lt};
				ACT_AND, ACT_ANDI: value = a & opb;
				ACT_OR, ACT_ORI:   value = a | opb;
				ACT_XOR, ACT_XORI: value = a ^ opb;
				ACT_SLL:           value = a << b[4:0];
				ACT_SRL:           value = a >> b[4:0];
				ACT_SUB:           value = a - b;
				ACT_JALR, ACT_JAL: value = pc1;
				ACT_LI:            value = s1_d.item.immediate;
				ACT_BEQ:           taken = eq;
				ACT_BNE:           taken = !eq;
				ACT_BLT:           taken = lt;
				ACT_BGE:           taken = !lt;
				ACT_BLE:           taken = lt || eq;
				ACT_J:             taken = 1'b1;
				default:           value = '0;
			endcase
			if (s1_d.cls.is_jalr) begin
				nx.next_pc = sum;
			end
			if (s1_d.cls.is_jal) begin
				if (!s1_d.item.label_given) begin
					nx.next_pc = pc_q + s1_d.item.immediate;
				end else if (s1_d.item.target_known) begin
					nx.next_pc = tgt;
				end else begin
					nx.fault = FLT_LABEL;
				end
			end
			if (s1_d.cls.is_branch && taken) begin
				if (s1_d.item.target_known) begin
					nx.next_pc = tgt;
				end else begin
					nx.fault = FLT_LABEL;
				end
			end
			if (s1_d.cls.is_lw || s1_d.cls.is_sw) begin
				nx.fault = mfault;
				nx_load  = s1_d.cls.is_lw;
				st_en    = s1_d.cls.is_sw;
			end
			if (nx.fault != FLT_NONE) begin
				wr         = 1'b0;
				st_en      = 1'b0;
				nx.next_pc = pc_q;
			end
			if (s1_d.item.dest_reg == 5'd0) begin
				wr = 1'b0;
			end
			nx_load          = nx_load && wr;
			nx.reg_written   = wr;
			nx.written_reg   = wr ? s1_d.item.dest_reg : 5'd0;
			nx.written_value = (wr && !nx_load) ? value : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			rv_q       <= '0;
			s1_valid   <= 1'b0;
			s2_valid   <= 1'b0;
			wb_valid_q <= 1'b0;
			pc_q       <= '0;
			halt_q     <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == DW_AW'(DATA_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (wb_en) begin
				rv_q[s2_d.written_reg] <= 1'b1;
			end
			if (adv) begin
				s1_valid   <= pop;
				s2_valid   <= s1_valid;
				wb_valid_q <= wb_en;
				if (s1_valid) begin
					pc_q <= nx.next_pc;
					if (halt_set) begin
						halt_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wb_rd_q  <= s2_d.written_reg;
			wb_val_q <= s2_val;
			if (pop) begin
				s1_d  <= head;
				s1_va <= rv_q[head.item.src_reg_a];
				s1_vb <= rv_q[head.item.src_reg_b];
			end
			if (s1_valid) begin
				s2_d    <= nx;
				s2_load <= nx_load;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/risc_subset_instruction_executor.sv -----
// top level of the rv32i subset executor: front end, queue, back end
// depends on rsie_pkg, rsie_if, rsie_front, rsie_queue, rsie_back
//
// channel | dir | payload    | transfer when
// inst    | in  | in_item_t  | inst.valid && inst.ready
// res     | out | out_item_t | res.valid && res.ready
//
// one instruction per cycle sustained while res is ready and the memory sweep is done;
// an instruction passes the front register, queue, operand stage and result register.
// after reset the data memory is swept to zero, all DATA_WORDS (1024) words;
// up to three instructions are taken meanwhile and wait in the front register and queue.
// a stalled res holds the back end; the queue lets the front keep accepting until full.
`default_nettype none

module risc_subset_instruction_executor import rsie_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rsie_in_if.sink    inst,
	rsie_out_if.source res
);

	logic push;
	dec_t push_data;
	logic push_ready;
	logic head_valid;
	dec_t head;
	logic pop;

	rsie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.inst       (inst),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	rsie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	rsie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (res)
	);

endmodule

`default_nettype wire

// ----- sv/rsie_checker.sv -----
// port-level checks on the result channel of the executor, bound to the top level
// depends on rsie_pkg
`default_nettype none

module rsie_checker import rsie_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      res_valid,
	input wire logic      res_ready,
	input wire out_item_t res_data
);

	// a result waiting on the sink stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_dest: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.reg_written |-> res_data.written_reg != 5'd0)
		else $error("write reported to x0");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.reg_written |->
		res_data.written_reg == 5'd0 && res_data.written_value == 32'sd0)
		else $error("stale write fields without a write");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.fault != FLT_NONE || res_data.halted) |->
		!res_data.reg_written && !(res_data.halted && res_data.fault != FLT_NONE))
		else $error("faulted or halted result carries a write");

endmodule

bind risc_subset_instruction_executor rsie_checker u_rsie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

`default_nettype wire
